>>> src/ia32enc_pkg.sv
`default_nettype none
package ia32enc_pkg;

    localparam int ActionWidth = 5;
    localparam int KindWidth   = 3;
    localparam int RegWidth    = 3;
    localparam int ValueWidth  = 32;
    localparam int MaxBytes    = 10;
    localparam int CountWidth  = 4;

    typedef enum logic [ActionWidth-1:0] {
        ACT_MOV = 5'd0, ACT_AND = 5'd1, ACT_INC = 5'd2, ACT_DEC = 5'd3,
        ACT_ADD = 5'd4, ACT_SUB = 5'd5, ACT_MUL = 5'd6, ACT_DIV = 5'd7,
        ACT_SAL = 5'd8, ACT_SAR = 5'd9, ACT_XOR = 5'd10, ACT_CMP = 5'd11,
        ACT_PUSH = 5'd12, ACT_POP = 5'd13, ACT_RET = 5'd14, ACT_CALL = 5'd15,
        ACT_JMP = 5'd16, ACT_JE = 5'd17, ACT_JNE = 5'd18, ACT_JG = 5'd19,
        ACT_JGE = 5'd20, ACT_JL = 5'd21, ACT_JLE = 5'd22
    } t_action;

    localparam logic [KindWidth-1:0] K_REG = 3'd1;
    localparam logic [KindWidth-1:0] K_IMM = 3'd2;
    localparam logic [KindWidth-1:0] K_ABS = 3'd3;
    localparam logic [KindWidth-1:0] K_D8  = 3'd4;
    localparam logic [KindWidth-1:0] K_D32 = 3'd5;
    localparam logic [KindWidth-1:0] K_IND = 3'd6;
    localparam logic [RegWidth-1:0]  R_EAX = 3'd0;
    localparam logic [RegWidth-1:0]  R_EBP = 3'd5;

    typedef struct packed {
        logic [ActionWidth-1:0] action;
        logic [KindWidth-1:0]   dst_kind;
        logic [RegWidth-1:0]    dst_reg;
        logic [ValueWidth-1:0]  dst_value;
        logic [KindWidth-1:0]   src_kind;
        logic [RegWidth-1:0]    src_reg;
        logic [ValueWidth-1:0]  src_value;
    } t_instr;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last;
        logic       error;
    } t_result;

    // Whole encoded instruction: byte 0 goes out first
    typedef struct packed {
        logic [MaxBytes-1:0][7:0] bytes;
        logic [CountWidth-1:0]    count;
        logic                     error;
    } t_encoding;

endpackage
`default_nettype wire

>>> src/ia32enc_stream_if.sv
`default_nettype none
interface ia32enc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> src/ia32_instruction_encoder_unit.sv
// x86 32-bit instruction encoder.
// Input channel (i_instr): one abstract instruction per transfer.
// Output channel (o_result): one machine-code byte per transfer, in order,
// with last set on the final byte; an unsupported form gives a single
// transfer with code_byte zero, last and error set.
// An accepted instruction is registered in the input register, encoded by
// combinational logic, and the whole byte string (up to ten bytes) is loaded
// into the output buffer once the buffer frees. The first byte is then
// presented and transfers at the following edge at the earliest.
// Throughput: one byte per cycle at the output buffer while the receiver is
// ready; a next instruction waiting in the input register is loaded while the
// last byte of the current one transfers, giving back-to-back streams with no gap.
// A stalled receiver holds the current byte; the input register then fills
// and input ready drops until the buffer frees.
// Synchronous reset empties both registers; nothing is output after reset.
`default_nettype none
module ia32_instruction_encoder_unit
    import ia32enc_pkg::*;
(
    input  var logic       i_clk,
    input  var logic       i_rst_n,
    ia32enc_stream_if.sink   i_instr,
    ia32enc_stream_if.source o_result
);

    t_instr    r_instr;
    logic      r_full;
    t_encoding w_enc;
    logic      w_free;
    logic      w_load;

    assign w_load        = r_full && w_free;
    assign i_instr.ready = !r_full || w_free;

    // Input register stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_full <= 1'b0;
        else if (i_instr.ready) r_full <= i_instr.valid;
        if (i_instr.ready && i_instr.valid) r_instr <= i_instr.payload;
    end

    ia32enc_encoder u_enc (.i_instr(r_instr), .o_enc(w_enc));

    ia32enc_serialiser u_ser (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (w_load),
        .i_enc  (w_enc),
        .o_free (w_free),
        .o_res  (o_result)
    );

    // Error results are a single zero byte
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.payload.error |->
            o_result.payload.last && o_result.payload.code_byte == 8'h00)
        else $error("error result not a lone zero byte");

    // Stalled input register holds its instruction
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full && !w_free |=> r_full && $stable(r_instr))
        else $error("input register lost a waiting instruction");

    // Load only when the buffer frees; a loaded encoding is then presented
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_result.valid)
        else $error("loaded encoding not presented");

endmodule
`default_nettype wire

>>> src/ia32enc_encoder.sv
`default_nettype none
module ia32enc_encoder
    import ia32enc_pkg::*;
(
    input  var t_instr    i_instr,
    output var t_encoding o_enc
);

    // Byte assembly buffer, filled in emission order
    always_comb begin
        logic [MaxBytes-1:0][7:0] b;
        logic [CountWidth-1:0]    n;
        logic                     fail;
        logic [KindWidth-1:0]     dk, sk;
        logic [RegWidth-1:0]      dr, sr;
        logic [31:0]              dv, sv;
        logic                     dmem, smem;
        logic [7:0]               op_rr, op_rm, op_eax;
        logic [2:0]               ext;
        logic                     is_alu;
        logic [2:0]               mreg;
        logic [KindWidth-1:0]     mkind;
        logic [RegWidth-1:0]      mbase;
        logic [31:0]              mval;
        logic                     use_m;
        logic                     one;
        b = '0; n = '0; fail = 1'b0;
        dk = i_instr.dst_kind; sk = i_instr.src_kind;
        dr = i_instr.dst_reg;  sr = i_instr.src_reg;
        dv = i_instr.dst_value; sv = i_instr.src_value;
        dmem = (dk == K_ABS) || (dk == K_D8) || (dk == K_D32) || (dk == K_IND);
        smem = (sk == K_ABS) || (sk == K_D8) || (sk == K_D32) || (sk == K_IND);
        op_rr = 8'h00; op_rm = 8'h00; op_eax = 8'h00; ext = 3'd0; is_alu = 1'b1;
        mreg = 3'd0; mkind = dk; mbase = dr; mval = dv; use_m = 1'b0;
        one = (sv == 32'd1);

        // ALU opcode table
        unique case (i_instr.action)
            ACT_AND: begin op_rr = 8'h21; op_rm = 8'h23; op_eax = 8'h25; ext = 3'd4; end
            ACT_ADD: begin op_rr = 8'h01; op_rm = 8'h03; op_eax = 8'h05; ext = 3'd0; end
            ACT_SUB: begin op_rr = 8'h29; op_rm = 8'h2B; op_eax = 8'h2D; ext = 3'd5; end
            ACT_XOR: begin op_rr = 8'h31; op_rm = 8'h33; op_eax = 8'h35; ext = 3'd6; end
            ACT_CMP: begin op_rr = 8'h39; op_rm = 8'h3B; op_eax = 8'h3D; ext = 3'd7; end
            default: is_alu = 1'b0;
        endcase

        // Opcode bytes; a memory operand is appended afterwards
        if (is_alu) begin
            if (sk == K_REG && dk == K_REG) begin
                b[0] = op_rr; b[1] = {2'b11, sr, dr}; n = 4'd2;
            end else if (smem && dk == K_REG) begin
                b[0] = op_rm; n = 4'd1; use_m = 1'b1;
                mreg = dr; mkind = sk; mbase = sr; mval = sv;
            end else if (sk == K_REG && dmem) begin
                b[0] = op_rr; n = 4'd1; use_m = 1'b1; mreg = sr;
            end else if (sk == K_IMM && dk == K_REG && dr == R_EAX) begin
                b[0] = op_eax; b[4:1] = sv; n = 4'd5;
            end else if (sk == K_IMM && dk == K_REG) begin
                b[0] = 8'h81; b[1] = {2'b11, ext, dr}; b[5:2] = sv; n = 4'd6;
            end else if (sk == K_IMM && dmem) begin
                b[0] = 8'h81; n = 4'd1; use_m = 1'b1; mreg = ext;
            end else fail = 1'b1;
        end else begin
            unique case (i_instr.action)
                ACT_MOV: begin
                    if (sk == K_REG && dk == K_REG) begin
                        b[0] = 8'h89; b[1] = {2'b11, sr, dr}; n = 4'd2;
                    end else if (sk == K_ABS && dk == K_REG && dr == R_EAX) begin
                        b[0] = 8'hA1; b[4:1] = sv; n = 4'd5;
                    end else if (smem && dk == K_REG) begin
                        b[0] = 8'h8B; n = 4'd1; use_m = 1'b1;
                        mreg = dr; mkind = sk; mbase = sr; mval = sv;
                    end else if (sk == K_REG && dk == K_ABS && sr == R_EAX) begin
                        b[0] = 8'hA3; b[4:1] = dv; n = 4'd5;
                    end else if (sk == K_REG && dmem) begin
                        b[0] = 8'h89; n = 4'd1; use_m = 1'b1; mreg = sr;
                    end else if (sk == K_IMM && dk == K_REG) begin
                        b[0] = {5'b10111, dr}; b[4:1] = sv; n = 4'd5;
                    end else if (sk == K_IMM && dmem) begin
                        b[0] = 8'hC7; n = 4'd1; use_m = 1'b1; mreg = 3'd0;
                    end else fail = 1'b1;
                end
                ACT_MUL: begin
                    if (sk == K_REG && dk == K_REG && sr == R_EAX) begin
                        b[0] = 8'hF7; b[1] = {5'b11101, dr}; n = 4'd2;
                    end else if (sk == K_REG && dmem && sr == R_EAX) begin
                        b[0] = 8'hF7; n = 4'd1; use_m = 1'b1; mreg = 3'd5;
                    end else if (sk == K_REG && dk == K_REG) begin
                        b[0] = 8'h0F; b[1] = 8'hAF; b[2] = {2'b11, sr, dr}; n = 4'd3;
                    end else if (sk == K_REG && dmem) begin
                        b[0] = 8'h0F; b[1] = 8'hAF; n = 4'd2; use_m = 1'b1; mreg = sr;
                    end else if (sk == K_IMM && dk == K_REG) begin
                        b[0] = 8'h69; b[1] = {2'b11, dr, dr}; b[5:2] = sv; n = 4'd6;
                    end else if (smem && dk == K_REG) begin
                        b[0] = 8'h0F; b[1] = 8'hAF; n = 4'd2; use_m = 1'b1;
                        mreg = dr; mkind = sk; mbase = sr; mval = sv;
                    end else fail = 1'b1;
                end
                ACT_INC, ACT_DEC, ACT_POP, ACT_PUSH: begin
                    if (i_instr.action == ACT_PUSH && dk == K_IMM) begin
                        b[0] = 8'h68; b[4:1] = dv; n = 4'd5;
                    end else if (dk == K_REG) begin
                        unique case (i_instr.action)
                            ACT_INC: b[0] = {5'b01000, dr};
                            ACT_DEC: b[0] = {5'b01001, dr};
                            ACT_PUSH: b[0] = {5'b01010, dr};
                            default: b[0] = {5'b01011, dr};
                        endcase
                        n = 4'd1;
                    end else if (dmem) begin
                        b[0] = (i_instr.action == ACT_POP) ? 8'h8F : 8'hFF;
                        n = 4'd1; use_m = 1'b1;
                        unique case (i_instr.action)
                            ACT_DEC: mreg = 3'd1;
                            ACT_PUSH: mreg = 3'd6;
                            default: mreg = 3'd0;
                        endcase
                    end else fail = 1'b1;
                end
                ACT_DIV: begin
                    if (dk == K_REG) begin
                        b[0] = 8'hF7; b[1] = {5'b11110, dr}; n = 4'd2;
                    end else if (dmem) begin
                        b[0] = 8'hF7; n = 4'd1; use_m = 1'b1; mreg = 3'd6;
                    end else fail = 1'b1;
                end
                ACT_SAL, ACT_SAR: begin
                    mreg = (i_instr.action == ACT_SAL) ? 3'd4 : 3'd7;
                    if (sk != K_IMM || !(dk == K_REG || dmem)) fail = 1'b1;
                    else if (!one && !(sv <= 32'h7F || sv >= 32'hFFFF_FF80)) fail = 1'b1;
                    else begin
                        b[0] = one ? 8'hD1 : 8'hC1; n = 4'd1;
                        if (dk == K_REG) begin
                            b[1] = {2'b11, mreg, dr}; n = 4'd2;
                        end else use_m = 1'b1;
                    end
                end
                ACT_RET: begin b[0] = 8'hC3; n = 4'd1; end
                ACT_CALL: begin
                    if (dmem) begin
                        b[0] = 8'hFF; n = 4'd1; use_m = 1'b1; mreg = 3'd2;
                    end else fail = 1'b1;
                end
                ACT_JMP: begin b[0] = 8'hE9; b[4:1] = dv; n = 4'd5; end
                ACT_JE, ACT_JNE, ACT_JG, ACT_JGE, ACT_JL, ACT_JLE: begin
                    b[0] = 8'h0F; b[5:2] = dv; n = 4'd6;
                    unique case (i_instr.action)
                        ACT_JE:  b[1] = 8'h84;
                        ACT_JNE: b[1] = 8'h85;
                        ACT_JG:  b[1] = 8'h8F;
                        ACT_JGE: b[1] = 8'h8D;
                        ACT_JL:  b[1] = 8'h8C;
                        default: b[1] = 8'h8E;
                    endcase
                end
                default: fail = 1'b1;
            endcase
        end

        // Memory operand: ModRM plus displacement, then trailing immediate
        if (use_m) begin
            if (mkind == K_ABS) begin
                b[n] = {2'b00, mreg, 3'd5}; b[n+1] = mval[7:0]; b[n+2] = mval[15:8];
                b[n+3] = mval[23:16]; b[n+4] = mval[31:24]; n = n + 4'd5;
            end else if (mkind == K_D8 && mbase == R_EBP) begin
                b[n] = {2'b01, mreg, 3'd5}; b[n+1] = mval[7:0]; n = n + 4'd2;
            end else if (mkind == K_D32 && mbase == R_EBP) begin
                b[n] = {2'b10, mreg, 3'd5}; b[n+1] = mval[7:0]; b[n+2] = mval[15:8];
                b[n+3] = mval[23:16]; b[n+4] = mval[31:24]; n = n + 4'd5;
            end else fail = 1'b1;
            if (!fail) begin
                if (i_instr.action == ACT_SAL || i_instr.action == ACT_SAR) begin
                    if (!one) begin b[n] = sv[7:0]; n = n + 4'd1; end
                end else if (sk == K_IMM && (i_instr.action == ACT_MOV || is_alu)) begin
                    b[n] = sv[7:0]; b[n+1] = sv[15:8]; b[n+2] = sv[23:16];
                    b[n+3] = sv[31:24]; n = n + 4'd4;
                end
            end
        end else if ((i_instr.action == ACT_SAL || i_instr.action == ACT_SAR)
                     && !fail && !one) begin
            b[n] = sv[7:0]; n = n + 4'd1;
        end

        o_enc.bytes = b;
        o_enc.count = n;
        o_enc.error = fail;
    end

endmodule
`default_nettype wire

>>> src/ia32enc_serialiser.sv
`default_nettype none
module ia32enc_serialiser
    import ia32enc_pkg::*;
(
    input  var logic       i_clk,
    input  var logic       i_rst_n,
    input  var logic       i_load,
    input  var t_encoding  i_enc,
    output var logic       o_free,
    ia32enc_stream_if.source o_res
);

    t_encoding             r_enc, n_enc;
    logic [CountWidth-1:0] r_idx, n_idx;
    logic                  r_busy, n_busy;
    logic                  w_err, w_last;

    assign w_err  = r_enc.error || (r_enc.count == '0);
    assign w_last = w_err || (r_idx == r_enc.count - 4'd1);
    assign o_free = !r_busy || (o_res.ready && w_last);

    assign o_res.valid             = r_busy;
    assign o_res.payload.code_byte = w_err ? 8'h00 : r_enc.bytes[r_idx];
    assign o_res.payload.last      = w_last;
    assign o_res.payload.error     = w_err;

    // Byte pointer: advance on each transfer, reload on a new encoding
    always_comb begin
        n_enc  = r_enc;
        n_idx  = r_idx;
        n_busy = r_busy;
        if (r_busy && o_res.ready) begin
            n_idx = r_idx + 4'd1;
            if (w_last) n_busy = 1'b0;
        end
        if (i_load) begin
            n_enc  = i_enc;
            n_idx  = '0;
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
        r_enc <= n_enc;
    end

endmodule
`default_nettype wire
